// ===== rtl/core/pcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_pkg - positional card list shared definitions
// Sizes, opcodes, status codes and the control bundle that is passed down
// the cell row.
// ----------------------------------------------------------------------------
package pcl_pkg;

	localparam int CAPACITY = 64;
	// cells are reduced in groups of eight
	localparam int GRP      = 8;
	localparam int GRPW     = $clog2(GRP);
	localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
	localparam int NCELL    = NGRP * GRP;
	localparam int NGRPW    = (NGRP > 1) ? $clog2(NGRP) : 1;
	// index / position arithmetic width, never narrower than the position field
	localparam int IW       = ($clog2(NCELL + 1) > 7) ? $clog2(NCELL + 1) : 7;
	localparam int CNTW     = $clog2(CAPACITY + 1);
	localparam int CARDW    = 6;

	localparam int IN_W     = 16;
	localparam int OUT_W    = 24;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_FIND   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef logic [CARDW-1:0] card_t;

	// broadcast to every cell
	typedef struct packed {
		logic          ins;    // shift down and write key at idx
		logic          rem;    // shift up from idx
		logic [IW-1:0] idx;    // target slot
		logic [IW-1:0] count;  // cards held before this operation
		card_t         key;    // card to insert or find
	} cell_ctrl_t;

	// per-group reduction result
	typedef struct packed {
		logic            hit;   // some cell of the group matches the key
		logic [GRPW-1:0] first; // first matching cell within the group
		card_t           card;  // card of the selected cell, zero if none
	} grp_res_t;

endpackage

// ===== rtl/core/positional_card_list_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_card_list_core - ordered card list with positional access
// Insert, remove, read and find on a list of up to CAPACITY cards held in a
// row of shifting cells.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one output beat. The accepting edge registers
// the beat in the input register. Then the whole cell row shifts and the
// per-group match/select reduction is registered along with it, and the group
// results are merged into the output register once it is empty or being read.
// Only one operation is in flight at a time. A new beat is not taken until the
// previous result has left stage 2; it is taken later while the output register
// is still full and m_tready is low. The input is also taken while a finished
// result still waits on the output. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module positional_card_list_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// opcode[1:0], position[8:2], card_suit[10:9], card_value[14:11], zero[15]
	input  logic [pcl_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// out_suit[1:0], out_value[5:2], out_position[11:6], list_count[18:12],
	// status[20:19], zero[23:21]
	output logic [pcl_pkg::OUT_W-1:0] m_tdata
);
	import pcl_pkg::*;

	// stage registers
	logic             v_s1, v_s2;
	logic [1:0]       op_s1, op_s2;
	logic [6:0]       pos_s1;
	card_t            key_s1;
	logic [1:0]       st_s2;
	logic [CNTW-1:0]  count_q;
	logic             out_v_q;
	logic [OUT_W-1:0] out_q;

	logic            in_acc;
	logic            out_go;
	logic            neg;
	logic [IW-1:0]   p;
	logic [IW-1:0]   cnt;
	logic [IW-1:0]   idx;
	logic            is_full, is_empty;
	logic [1:0]      st_nxt;
	cell_ctrl_t      ctrl;

	card_t           card_w [NCELL];
	logic [NCELL-1:0] sel_w, match_w;
	grp_res_t        res_w [NGRP];

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = !v_s1 && !v_s2;
	assign out_go   = v_s2 && (!out_v_q || m_tready);

	// input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= s_tdata[1:0];
			pos_s1 <= s_tdata[8:2];
			key_s1 <= {s_tdata[10:9], s_tdata[14:11]};
		end
	end

	// target slot and status
	assign neg      = pos_s1[6];
	assign p        = IW'(pos_s1[5:0]);
	assign cnt      = IW'(count_q);
	assign is_full  = (cnt == IW'(CAPACITY));
	assign is_empty = (cnt == '0);

	always_comb begin
		idx    = '0;
		st_nxt = ST_OK;
		case (op_s1)
			OP_INSERT: begin
				if (is_full)
					st_nxt = ST_FULL;
				if (is_empty || (!neg && p == '0))
					idx = '0;
				else if (neg || p >= cnt)
					idx = cnt;
				else
					idx = p;
			end
			OP_REMOVE, OP_READ: begin
				if (is_empty)
					st_nxt = ST_EMPTY;
				if (op_s1 == OP_REMOVE && (cnt == IW'(1) || (!neg && p == '0)))
					idx = '0;
				else if (neg || p >= cnt - IW'(1))
					idx = cnt - IW'(1);
				else
					idx = p;
			end
			default: begin
				idx    = '0;
				st_nxt = ST_OK;
			end
		endcase
	end

	assign ctrl.ins   = v_s1 && op_s1 == OP_INSERT && !is_full;
	assign ctrl.rem   = v_s1 && op_s1 == OP_REMOVE && !is_empty;
	assign ctrl.idx   = idx;
	assign ctrl.count = cnt;
	assign ctrl.key   = key_s1;

	// card count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ins) begin
			count_q <= count_q + CNTW'(1);
		end else if (ctrl.rem) begin
			count_q <= count_q - CNTW'(1);
		end
	end

	// cell row
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		card_t above_w, below_w;
		if (i == 0) begin : g_top
			assign above_w = '0;
		end else begin : g_mid
			assign above_w = card_w[i-1];
		end
		if (i == NCELL - 1) begin : g_bot
			assign below_w = '0;
		end else begin : g_nbot
			assign below_w = card_w[i+1];
		end
		pcl_cell u_cell (
			.clk   (clk),
			.slot  (IW'(i)),
			.ctrl  (ctrl),
			.above (above_w),
			.below (below_w),
			.card  (card_w[i]),
			.sel   (sel_w[i]),
			.match (match_w[i])
		);
	end

	// group reductions, registered at the end of stage 1
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		card_t gcard [GRP];
		for (genvar j = 0; j < GRP; j++) begin : g_tap
			assign gcard[j] = card_w[g*GRP + j];
		end
		pcl_group u_grp (
			.clk   (clk),
			.en    (v_s1),
			.match (match_w[g*GRP +: GRP]),
			.sel   (sel_w[g*GRP +: GRP]),
			.card  (gcard),
			.res   (res_w[g])
		);
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (v_s1) begin
			v_s2 <= 1'b1;
		end else if (out_go) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			op_s2 <= op_s1;
			st_s2 <= st_nxt;
		end
	end

	// merge groups into the result beat
	logic            f_hit;
	logic [IW-1:0]   f_pos;
	card_t           r_card;
	logic [1:0]      r_st;
	card_t           o_card;
	logic [IW-1:0]   o_pos;

	always_comb begin
		f_hit  = 1'b0;
		f_pos  = '0;
		r_card = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (res_w[g].hit) begin
				f_hit = 1'b1;
				f_pos = IW'({NGRPW'(g), res_w[g].first});
			end
		end
		for (int g = 0; g < NGRP; g++)
			r_card = r_card | res_w[g].card;
	end

	always_comb begin
		o_card = '0;
		o_pos  = '0;
		r_st   = st_s2;
		case (op_s2)
			OP_REMOVE, OP_READ: begin
				if (st_s2 == ST_OK)
					o_card = r_card;
			end
			OP_FIND: begin
				if (f_hit)
					o_pos = f_pos;
				else
					r_st = ST_NOTFOUND;
			end
			default: begin
				o_card = '0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_go) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_go)
			out_q <= {3'b000, r_st, cnt[6:0],
				o_pos[5:0], o_card[3:0], o_card[5:4]};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// checks
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= IW'(CAPACITY))
		else $error("card count above capacity");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2}))
		else $error("more than one operation in flight");

	a_acc_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> ##1 v_s2)
		else $error("accepted beat did not reach stage 2");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_go && r_st == ST_FULL) |-> is_full)
		else $error("full status with room left");

endmodule

// ===== rtl/core/pcl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_cell - one slot of the card row
// Holds one card, takes a neighbour's card on insert/remove shifts and
// flags whether it is the addressed slot or a match for the key.
// ----------------------------------------------------------------------------
module pcl_cell (
	input  logic              clk,
	input  logic [pcl_pkg::IW-1:0] slot,    // this cell's position
	input  pcl_pkg::cell_ctrl_t    ctrl,
	input  pcl_pkg::card_t         above,   // card of the cell one nearer the top
	input  pcl_pkg::card_t         below,   // card of the cell one nearer the bottom
	output pcl_pkg::card_t         card,
	output logic                   sel,
	output logic                   match
);
	import pcl_pkg::*;

	card_t card_q;
	logic  at_idx;
	logic  past_idx;

	assign at_idx   = (slot == ctrl.idx);
	assign past_idx = (slot > ctrl.idx);
	assign card     = card_q;
	assign sel      = at_idx;
	assign match    = (slot < ctrl.count) && (card_q == ctrl.key);

	// slot update; contents past the count are don't care
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (at_idx)
				card_q <= ctrl.key;
			else if (past_idx)
				card_q <= above;
		end else if (ctrl.rem) begin
			if (at_idx || past_idx)
				card_q <= below;
		end
	end

endmodule

// ===== rtl/core/pcl_group.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_group - registered reduction over eight cells
// Finds the first matching cell and picks out the addressed card.
// ----------------------------------------------------------------------------
module pcl_group (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pcl_pkg::GRP-1:0]       match,
	input  logic [pcl_pkg::GRP-1:0]       sel,
	input  pcl_pkg::card_t                card [pcl_pkg::GRP],
	output pcl_pkg::grp_res_t             res
);
	import pcl_pkg::*;

	grp_res_t res_s2;
	grp_res_t nxt;

	// priority from the top slot, OR of selected cards
	always_comb begin
		nxt = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (match[i]) begin
				nxt.hit   = 1'b1;
				nxt.first = GRPW'(i);
			end
		end
		for (int i = 0; i < GRP; i++) begin
			if (sel[i])
				nxt.card = nxt.card | card[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s2 <= nxt;
	end

	assign res = res_s2;

endmodule
